[sv/v3n_pkg.sv]
// v3n_pkg: shared constants and the status type for the vector normalizer.
// No dependencies.
package v3n_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int IN_W          = 32;
  localparam int UNIT_W        = 18;
  localparam int LEN_W         = 33;
  localparam int SQ_W          = 64;
  localparam int NORM_W        = 32;
  localparam logic [IN_W-1:0] EPS_RESET = 32'd1;

  typedef enum logic {
    STAT_OK  = 1'b0,
    STAT_LOW = 1'b1
  } status_t;
endpackage

[sv/vector3_normalize_top.sv]
// vector3_normalize_top: 3-vector normalizer, Q16.16 in, Q1.FRAC_BITS unit out.
// Pipeline: abs stage, 2 square/sum stages, 32 sqrt stages, (32+FRAC_BITS)
// divide stages and an output stage. Throughput: one item per cycle; set by
// the fully unrolled sqrt and divide pipelines, one result bit per stage.
// Reset: synchronous active low, clears valid bits, epsilon returns to 1.
// busy is always low; results are strobed for one cycle, no stall.
// Depends on v3n_pkg.
module vector3_normalize_top #(
  parameter int FRAC_BITS = v3n_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [31:0]         in_vec_x,
  input  logic signed [31:0]         in_vec_y,
  input  logic signed [31:0]         in_vec_z,
  output logic                       out_valid,
  output logic signed [17:0]         out_unit_x,
  output logic signed [17:0]         out_unit_y,
  output logic signed [17:0]         out_unit_z,
  output logic [32:0]                out_vec_length,
  output logic                       out_status,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [31:0]                cfg_data
);
  import v3n_pkg::*;

  localparam int SQS = NORM_W;            // sqrt stages
  localparam int DW  = IN_W + FRAC_BITS;  // dividend width
  localparam int DVS = DW;                // divide stages

  logic [IN_W-1:0] eps_r;
  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) eps_r <= EPS_RESET;
    else if (cfg_valid) eps_r <= cfg_data;
  end

  // stage A: magnitudes
  logic            a_v_r;
  logic [IN_W-1:0] a_m_r [3];
  logic [2:0]      a_n_r;
  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else a_v_r <= start;
    a_n_r <= {in_vec_z[31], in_vec_y[31], in_vec_x[31]};
    a_m_r[0] <= in_vec_x[31] ? IN_W'(-in_vec_x) : in_vec_x;
    a_m_r[1] <= in_vec_y[31] ? IN_W'(-in_vec_y) : in_vec_y;
    a_m_r[2] <= in_vec_z[31] ? IN_W'(-in_vec_z) : in_vec_z;
  end

  // stage B: squares
  logic            b_v_r;
  logic [SQ_W-1:0] b_sq_r [3];
  logic [IN_W-1:0] b_m_r [3];
  logic [2:0]      b_n_r;
  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else b_v_r <= a_v_r;
    b_n_r <= a_n_r;
    for (int i = 0; i < 3; i++) begin
      b_m_r[i]  <= a_m_r[i];
      b_sq_r[i] <= SQ_W'(a_m_r[i]) * SQ_W'(a_m_r[i]);
    end
  end

  // stage C: sum
  logic            c_v_r;
  logic [SQ_W-1:0] c_sum_r;
  logic [IN_W-1:0] c_m_r [3];
  logic [2:0]      c_n_r;
  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else c_v_r <= b_v_r;
    c_n_r   <= b_n_r;
    c_m_r   <= b_m_r;
    c_sum_r <= b_sq_r[0] + b_sq_r[1] + b_sq_r[2];
  end

  // sqrt pipeline: restoring, one root bit per stage
  logic              s_v_r   [SQS+1];
  logic [SQ_W-1:0]   s_rem_r [SQS+1];
  logic [NORM_W-1:0] s_rt_r  [SQS+1];
  logic [IN_W-1:0]   s_m_r   [SQS+1][3];
  logic [2:0]        s_n_r   [SQS+1];
  always_comb begin
    s_v_r[0]   = c_v_r;
    s_rem_r[0] = c_sum_r;
    s_rt_r[0]  = '0;
    s_m_r[0]   = c_m_r;
    s_n_r[0]   = c_n_r;
  end
  for (genvar k = 0; k < SQS; k++) begin : g_sqrt
    localparam int B = SQS - 1 - k;
    logic [NORM_W-1:0] trial;
    logic [SQ_W-1:0]   tsq;
    assign trial = s_rt_r[k] | (NORM_W'(1) << B);
    // rem holds sum - rt^2; trial^2 - rt^2 = (2rt + 2^B) << B
    assign tsq = ((SQ_W'(s_rt_r[k]) << 1) + (SQ_W'(1) << B)) << B;
    always_ff @(posedge clk) begin
      if (!rst_n) s_v_r[k+1] <= 1'b0;
      else s_v_r[k+1] <= s_v_r[k];
      s_m_r[k+1] <= s_m_r[k];
      s_n_r[k+1] <= s_n_r[k];
      if (s_rem_r[k] >= tsq) begin
        s_rem_r[k+1] <= s_rem_r[k] - tsq;
        s_rt_r[k+1]  <= trial;
      end else begin
        s_rem_r[k+1] <= s_rem_r[k];
        s_rt_r[k+1]  <= s_rt_r[k];
      end
    end
  end

  // divide pipeline: three lanes, one quotient bit per stage
  logic              d_v_r   [DVS+1];
  logic [NORM_W-1:0] d_den_r [DVS+1];
  logic [2:0]        d_n_r   [DVS+1];
  logic              d_low_r [DVS+1];
  logic [DW-1:0]     d_num_r [DVS+1][3];
  logic [NORM_W:0]   d_rem_r [DVS+1][3];
  always_comb begin
    d_v_r[0]   = s_v_r[SQS];
    d_den_r[0] = s_rt_r[SQS];
    d_n_r[0]   = s_n_r[SQS];
    d_low_r[0] = s_rt_r[SQS] <= eps_r;
    for (int i = 0; i < 3; i++) begin
      d_num_r[0][i] = DW'(s_m_r[SQS][i]) << FRAC_BITS;
      d_rem_r[0][i] = '0;
    end
  end
  for (genvar k = 0; k < DVS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) d_v_r[k+1] <= 1'b0;
      else d_v_r[k+1] <= d_v_r[k];
      d_den_r[k+1] <= d_den_r[k];
      d_n_r[k+1]   <= d_n_r[k];
      d_low_r[k+1] <= d_low_r[k];
      for (int i = 0; i < 3; i++) begin
        logic [NORM_W:0] sh;
        sh = {d_rem_r[k][i][NORM_W-1:0], d_num_r[k][i][DW-1]};
        if (sh >= {1'b0, d_den_r[k]}) begin
          d_rem_r[k+1][i] <= sh - {1'b0, d_den_r[k]};
          d_num_r[k+1][i] <= {d_num_r[k][i][DW-2:0], 1'b1};
        end else begin
          d_rem_r[k+1][i] <= sh;
          d_num_r[k+1][i] <= {d_num_r[k][i][DW-2:0], 1'b0};
        end
      end
    end
  end

  // output stage
  logic               o_v_r;
  logic [UNIT_W-1:0]  o_u_r [3];
  logic [LEN_W-1:0]   o_len_r;
  status_t            o_st_r;
  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else o_v_r <= d_v_r[DVS];
    o_len_r <= LEN_W'(d_den_r[DVS]);
    o_st_r  <= d_low_r[DVS] ? STAT_LOW : STAT_OK;
    for (int i = 0; i < 3; i++) begin
      logic [UNIT_W-1:0] q;
      q = d_num_r[DVS][i][UNIT_W-1:0];
      if (d_low_r[DVS]) o_u_r[i] <= '0;
      else o_u_r[i] <= d_n_r[DVS][i] ? UNIT_W'(-q) : q;
    end
  end

  assign out_valid      = o_v_r;
  assign out_unit_x     = o_u_r[0];
  assign out_unit_y     = o_u_r[1];
  assign out_unit_z     = o_u_r[2];
  assign out_vec_length = o_len_r;
  assign out_status     = o_st_r;

  a_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_unit_x == '0 && out_unit_y == '0 && out_unit_z == '0)
    else $error("rejected item with nonzero unit");
  a_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    c_v_r |-> ##(SQS+DVS+1) out_valid)
    else $error("item lost in pipeline");
  a_zero_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_vec_length == '0 |-> out_status)
    else $error("zero norm accepted");
endmodule
